/* design/pbe_pkg.sv */
`timescale 1ns / 1ps

package pbe_pkg;

  localparam int unsigned ChBits     = 5;
  localparam int unsigned ColorBits  = 15;
  localparam int unsigned LayerBits  = 3;
  localparam int unsigned MaskBits   = 6;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 6;

  localparam logic [ChBits-1:0]    CH_MAX       = 5'd31;
  localparam logic [ChBits-1:0]    WEIGHT_MAX   = 5'd16;
  localparam logic [LayerBits-1:0] LAYER_OBJECT = 3'd4;

  localparam logic [CfgIdxBits-1:0] REG_FIRST_MASK  = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_SECOND_MASK = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_EFFECT_MODE = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_TOP_WEIGHT  = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_BOT_WEIGHT  = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_FADE        = 3'd5;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_ALPHA    = 2'd1,
    MODE_BRIGHTEN = 2'd2,
    MODE_DARKEN   = 2'd3
  } mode_t;

  typedef logic [ChBits-1:0]   weight_t;
  typedef logic [MaskBits-1:0] mask_t;

  typedef struct packed {
    logic [ColorBits-1:0] top_color;
    logic [LayerBits-1:0] top_layer;
    logic                 top_transparent;
    logic                 effect_allowed;
    logic                 top_semi_transparent;
    logic [ColorBits-1:0] bottom_color;
    logic [LayerBits-1:0] bottom_layer;
    logic                 bottom_transparent;
  } pixel_t;

  typedef struct packed {
    logic  apply;
    mode_t mode;
  } ctrl_t;

  function automatic weight_t clamp_weight(input weight_t w);
    return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
  endfunction

endpackage

/* design/pixel_blend_effects.sv */
`timescale 1ns / 1ps
// A word accepted with start passes the input register, then the result register,
// and appears on out_color with done high for one cycle.
// Throughput: one pixel per clock; busy is always low, as neither stage ever stalls.
// Reset clears all configuration registers to zero and both stage valid flags.
// The receiver cannot stall, so each result is shown for exactly one cycle.

module pixel_blend_effects import pbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ColorBits-1:0]  top_color,
  input  logic [LayerBits-1:0]  top_layer,
  input  logic                  top_transparent,
  input  logic                  effect_allowed,
  input  logic                  top_semi_transparent,
  input  logic [ColorBits-1:0]  bottom_color,
  input  logic [LayerBits-1:0]  bottom_layer,
  input  logic                  bottom_transparent,
  output logic                  done,
  output logic [ColorBits-1:0]  out_color,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [CfgBits-1:0]    cfg_data
);

  mask_t   first_target_mask;
  mask_t   second_target_mask;
  mode_t   effect_mode;
  weight_t top_weight;
  weight_t bottom_weight;
  weight_t fade_amount;

  pixel_t  pix;
  logic    pix_valid;
  ctrl_t   ctrl;
  logic [ColorBits-1:0] blended;
  logic [ColorBits-1:0] out_color_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_target_mask  <= '0;
      second_target_mask <= '0;
      effect_mode        <= MODE_NONE;
      top_weight         <= '0;
      bottom_weight      <= '0;
      fade_amount        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_MASK:  first_target_mask  <= cfg_data[MaskBits-1:0];
        REG_SECOND_MASK: second_target_mask <= cfg_data[MaskBits-1:0];
        REG_EFFECT_MODE: effect_mode        <= mode_t'(cfg_data[1:0]);
        REG_TOP_WEIGHT:  top_weight         <= cfg_data[ChBits-1:0];
        REG_BOT_WEIGHT:  bottom_weight      <= cfg_data[ChBits-1:0];
        REG_FADE:        fade_amount        <= cfg_data[ChBits-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= start && !busy;
    end
    if (start && !busy) begin
      pix.top_color            <= top_color;
      pix.top_layer            <= top_layer;
      pix.top_transparent      <= top_transparent;
      pix.effect_allowed       <= effect_allowed;
      pix.top_semi_transparent <= top_semi_transparent;
      pix.bottom_color         <= bottom_color;
      pix.bottom_layer         <= bottom_layer;
      pix.bottom_transparent   <= bottom_transparent;
    end
  end

  pbe_select u_select (
    .pix                (pix),
    .first_target_mask  (first_target_mask),
    .second_target_mask (second_target_mask),
    .effect_mode        (effect_mode),
    .ctrl               (ctrl)
  );

  for (genvar k = 0; k < 3; k++) begin : g_ch
    pbe_channel u_channel (
      .mode      (ctrl.mode),
      .top_ch    (pix.top_color[k*ChBits +: ChBits]),
      .bottom_ch (pix.bottom_color[k*ChBits +: ChBits]),
      .top_w     (clamp_weight(top_weight)),
      .bottom_w  (clamp_weight(bottom_weight)),
      .fade      (clamp_weight(fade_amount)),
      .out_ch    (blended[k*ChBits +: ChBits])
    );
  end

  assign out_color_next = ctrl.apply ? blended : pix.top_color;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pix_valid;
    end
    if (pix_valid) begin
      out_color <= out_color_next;
    end
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result strobe without an accepted word two cycles earlier");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    done && $past(!effect_allowed || top_transparent, 2) |-> out_color == $past(top_color, 2))
    else $error("pixel with effects off was not passed through");

  a_brighten_not_darker: assert property (@(posedge clk) disable iff (rst)
    done && $past(effect_mode == MODE_BRIGHTEN && !top_semi_transparent, 2)
    |-> out_color[ChBits-1:0] >= $past(top_color[ChBits-1:0], 2))
    else $error("brighten lowered the red channel");

endmodule

/* design/pbe_select.sv */
`timescale 1ns / 1ps

module pbe_select import pbe_pkg::*; (
  input  pixel_t pix,
  input  mask_t  first_target_mask,
  input  mask_t  second_target_mask,
  input  mode_t  effect_mode,
  output ctrl_t  ctrl
);

  logic [7:0] first_ext;
  logic [7:0] second_ext;
  logic       top_first;
  logic       bottom_ok;
  logic       forced;
  mode_t      mode;

  // Layer codes six and seven land on the zero padding, so they match no mask.
  assign first_ext  = {2'b00, first_target_mask};
  assign second_ext = {2'b00, second_target_mask};
  assign top_first  = first_ext[pix.top_layer];
  assign bottom_ok  = !pix.bottom_transparent && second_ext[pix.bottom_layer];
  assign forced     = (pix.top_layer == LAYER_OBJECT) && pix.top_semi_transparent && bottom_ok;

  always_comb begin
    mode = forced ? MODE_ALPHA : effect_mode;
    ctrl.mode  = mode;
    ctrl.apply = pix.effect_allowed && !pix.top_transparent && (forced || top_first)
                 && (mode != MODE_NONE) && !((mode == MODE_ALPHA) && !bottom_ok);
  end

endmodule

/* design/pbe_channel.sv */
`timescale 1ns / 1ps

module pbe_channel import pbe_pkg::*; (
  input  mode_t             mode,
  input  logic [ChBits-1:0] top_ch,
  input  logic [ChBits-1:0] bottom_ch,
  input  weight_t           top_w,
  input  weight_t           bottom_w,
  input  weight_t           fade,
  output logic [ChBits-1:0] out_ch
);

  logic [9:0]        top_prod;
  logic [9:0]        bottom_prod;
  logic [9:0]        fade_prod;
  logic [ChBits-1:0] fade_base;
  logic [6:0]        value;

  assign top_prod    = {5'b00000, top_w} * {5'b00000, top_ch};
  assign bottom_prod = {5'b00000, bottom_w} * {5'b00000, bottom_ch};
  // Brighten scales the headroom to white, darken scales the channel itself.
  assign fade_base   = (mode == MODE_BRIGHTEN) ? (CH_MAX - top_ch) : top_ch;
  assign fade_prod   = {5'b00000, fade} * {5'b00000, fade_base};

  always_comb begin
    case (mode)
      MODE_ALPHA:    value = {1'b0, top_prod[9:4]} + {1'b0, bottom_prod[9:4]};
      MODE_BRIGHTEN: value = {2'b00, top_ch} + {1'b0, fade_prod[9:4]};
      MODE_DARKEN:   value = {2'b00, top_ch} - {1'b0, fade_prod[9:4]};
      default:       value = {2'b00, top_ch};
    endcase
    out_ch = (value > {2'b00, CH_MAX}) ? CH_MAX : value[ChBits-1:0];
  end

endmodule

/* test/pixel_blend_effects_tb.sv */
`timescale 1ns / 1ps

module pixel_blend_effects_tb;
  import pbe_pkg::*;

  localparam int unsigned Sixteenths = 16;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    mask_t   first_mask;
    mask_t   second_mask;
    mode_t   mode;
    weight_t top_w;
    weight_t bot_w;
    weight_t fade;
  } fx_cfg_t;

  typedef struct packed {
    fx_cfg_t              cfg;
    pixel_t               px;
    logic                 typed;
    logic [ColorBits-1:0] want;
  } dir_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ColorBits-1:0]  top_color = '0;
  logic [LayerBits-1:0]  top_layer = '0;
  logic                  top_transparent = 1'b0;
  logic                  effect_allowed = 1'b0;
  logic                  top_semi_transparent = 1'b0;
  logic [ColorBits-1:0]  bottom_color = '0;
  logic [LayerBits-1:0]  bottom_layer = '0;
  logic                  bottom_transparent = 1'b0;
  logic                  done;
  logic [ColorBits-1:0]  out_color;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgBits-1:0]    cfg_data = '0;

  fx_cfg_t              cur_cfg = '0;
  logic [ColorBits-1:0] color_expect_q[$];
  dir_row_t             dir_rows[$];
  int unsigned          fail_count = 0;
  int unsigned          stuck_cycles = 0;
  int unsigned          idle_pct = 0;

  pixel_blend_effects DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .top_color           (top_color),
    .top_layer           (top_layer),
    .top_transparent     (top_transparent),
    .effect_allowed      (effect_allowed),
    .top_semi_transparent(top_semi_transparent),
    .bottom_color        (bottom_color),
    .bottom_layer        (bottom_layer),
    .bottom_transparent  (bottom_transparent),
    .done                (done),
    .out_color           (out_color),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic layer_selected(input mask_t m, input logic [LayerBits-1:0] l);
    return (l < MaskBits) ? m[l] : 1'b0;
  endfunction

  function automatic int unsigned clamped(input weight_t w);
    return (w > WEIGHT_MAX) ? int'(WEIGHT_MAX) : int'(w);
  endfunction

  // Final colour for one pixel pair under the current register settings.
  function automatic logic [ColorBits-1:0] blend_pixel(input pixel_t p);
    mode_t                m;
    logic                 bottom_ok;
    logic                 apply;
    logic [ColorBits-1:0] res;
    int unsigned          a, b, v, tw, bw, fw;
    m = cur_cfg.mode;
    tw = clamped(cur_cfg.top_w);
    bw = clamped(cur_cfg.bot_w);
    fw = clamped(cur_cfg.fade);
    bottom_ok = !p.bottom_transparent && layer_selected(cur_cfg.second_mask, p.bottom_layer);
    apply = 1'b1;
    if (!p.effect_allowed || p.top_transparent) begin
      apply = 1'b0;
    end else if (p.top_layer == LAYER_OBJECT && p.top_semi_transparent && bottom_ok) begin
      // A semi-transparent object over a second target always blends by alpha.
      m = MODE_ALPHA;
    end else if (!layer_selected(cur_cfg.first_mask, p.top_layer)) begin
      apply = 1'b0;
    end
    if (m == MODE_NONE || (m == MODE_ALPHA && !bottom_ok)) apply = 1'b0;
    if (!apply) return p.top_color;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      a = p.top_color[k*ChBits +: ChBits];
      b = p.bottom_color[k*ChBits +: ChBits];
      case (m)
        MODE_ALPHA:    v = tw * a / Sixteenths + b * bw / Sixteenths;
        MODE_BRIGHTEN: v = a + (int'(CH_MAX) - a) * fw / Sixteenths;
        default:       v = a - a * fw / Sixteenths;
      endcase
      if (v > CH_MAX) v = CH_MAX;
      res[k*ChBits +: ChBits] = ChBits'(v);
    end
    return res;
  endfunction

  function automatic fx_cfg_t mk_cfg(input mask_t f, input mask_t s, input mode_t m,
                                     input weight_t tw, input weight_t bw, input weight_t fd);
    fx_cfg_t c;
    c.first_mask  = f;
    c.second_mask = s;
    c.mode        = m;
    c.top_w       = tw;
    c.bot_w       = bw;
    c.fade        = fd;
    return c;
  endfunction

  function automatic pixel_t mk_px(input logic [ColorBits-1:0] tc, input logic [LayerBits-1:0] tl,
                                   input logic tt, input logic ea, input logic semi,
                                   input logic [ColorBits-1:0] bc, input logic [LayerBits-1:0] bl,
                                   input logic bt);
    pixel_t p;
    p.top_color            = tc;
    p.top_layer            = tl;
    p.top_transparent      = tt;
    p.effect_allowed       = ea;
    p.top_semi_transparent = semi;
    p.bottom_color         = bc;
    p.bottom_layer         = bl;
    p.bottom_transparent   = bt;
    return p;
  endfunction

  function automatic void add_row(input fx_cfg_t c, input pixel_t p, input logic typed,
                                  input logic [ColorBits-1:0] want);
    dir_row_t r;
    r.cfg   = c;
    r.px    = p;
    r.typed = typed;
    r.want  = want;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic weight_t pick_weight();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return WEIGHT_MAX;
      2:       return '1;
      default: return weight_t'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic mask_t pick_mask();
    return ($urandom_range(0, 1) == 0) ? '1 : mask_t'($urandom);
  endfunction

  function automatic logic [ColorBits-1:0] pick_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ColorBits'($urandom);
    endcase
  endfunction

  function automatic logic [LayerBits-1:0] pick_layer();
    case ($urandom_range(0, 9))
      0:       return LayerBits'($urandom_range(6, 7));
      1, 2, 3: return LAYER_OBJECT;
      default: return LayerBits'($urandom_range(0, 5));
    endcase
  endfunction

  // Mostly pixels that reach the effect logic, with a share that is bypassed.
  function automatic pixel_t rand_pixel();
    return mk_px(pick_color(), pick_layer(), $urandom_range(0, 9) == 0,
                 $urandom_range(0, 9) != 0, $urandom_range(0, 1) == 1,
                 pick_color(), pick_layer(), $urandom_range(0, 6) == 0);
  endfunction

  function automatic fx_cfg_t rand_cfg(input int unsigned batch);
    if (batch == 0) return mk_cfg('1, '1, mode_t'(2'($urandom)), '1, '1, '1);
    if (batch == 1) return mk_cfg('0, '0, MODE_NONE, '0, '0, '0);
    return mk_cfg(pick_mask(), pick_mask(), mode_t'(2'(batch % 4)),
                  pick_weight(), pick_weight(), pick_weight());
  endfunction

  task automatic send_word(input pixel_t p, input logic typed, input logic [ColorBits-1:0] want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start                <= 1'b1;
    top_color            <= p.top_color;
    top_layer            <= p.top_layer;
    top_transparent      <= p.top_transparent;
    effect_allowed       <= p.effect_allowed;
    top_semi_transparent <= p.top_semi_transparent;
    bottom_color         <= p.bottom_color;
    bottom_layer         <= p.bottom_layer;
    bottom_transparent   <= p.bottom_transparent;
    @(posedge clk);
    while (busy) @(posedge clk);
    color_expect_q = {color_expect_q, (typed ? want : blend_pixel(p))};
  endtask

  // Waits until every word in flight has come out, plus the pipeline depth.
  task automatic settle();
    start <= 1'b0;
    while (color_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_cfg(input fx_cfg_t c);
    settle();
    write_reg(REG_FIRST_MASK, c.first_mask);
    write_reg(REG_SECOND_MASK, c.second_mask);
    write_reg(REG_EFFECT_MODE, CfgBits'(c.mode));
    write_reg(REG_TOP_WEIGHT, CfgBits'(c.top_w));
    write_reg(REG_BOT_WEIGHT, CfgBits'(c.bot_w));
    write_reg(REG_FADE, CfgBits'(c.fade));
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic note_mismatch(input string what, input logic [ColorBits-1:0] want,
                               input logic [ColorBits-1:0] got);
    if (fail_count < ReportMax)
      $display("%0t: %s: expected out_color %h, got %h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (color_expect_q.size() == 0) begin
        note_mismatch("word with none expected", '0, out_color);
      end else if (out_color !== color_expect_q[0]) begin
        note_mismatch("wrong word", color_expect_q[0], out_color);
        void'(color_expect_q.pop_front());
      end else begin
        void'(color_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StallLimit) begin
      $display("pixel_blend_effects: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    fx_cfg_t zero_cfg, cfg_a, cfg_b, cfg_c, cfg_d, cfg_e, cfg_f, cfg_g;
    zero_cfg = mk_cfg('0, '0, MODE_NONE, '0, '0, '0);
    cfg_a    = mk_cfg('1, '1, MODE_ALPHA, 16, 16, 0);
    cfg_b    = mk_cfg('1, '1, MODE_ALPHA, 31, 31, 0);
    cfg_c    = mk_cfg('1, '0, MODE_BRIGHTEN, 0, 0, 16);
    cfg_d    = mk_cfg('1, '1, MODE_DARKEN, 0, 0, 31);
    cfg_e    = mk_cfg('0, 6'h01, MODE_NONE, 8, 8, 0);
    cfg_f    = mk_cfg(6'h10, 6'h01, MODE_DARKEN, 12, 5, 8);
    cfg_g    = mk_cfg('1, '1, MODE_ALPHA, 0, 0, 0);

    // Registers as left by reset: no effect at all.
    add_row(zero_cfg, mk_px(15'h7FFF, 0, 0, 1, 0, 15'h0000, 1, 0), 1, 15'h7FFF);
    add_row(zero_cfg, mk_px(15'h0000, 5, 0, 1, 1, 15'h7FFF, 5, 0), 1, 15'h0000);
    // Full weights saturate; bypass cases leave the top colour alone.
    add_row(cfg_a, mk_px(15'h7FFF, 0, 0, 1, 0, 15'h7FFF, 1, 0), 1, 15'h7FFF);
    add_row(cfg_a, mk_px(15'h0000, 3, 0, 1, 0, 15'h0000, 2, 0), 1, 15'h0000);
    add_row(cfg_a, mk_px(15'h1234, 0, 0, 0, 0, 15'h7FFF, 1, 0), 1, 15'h1234);
    add_row(cfg_a, mk_px(15'h4321, 1, 1, 1, 0, 15'h7FFF, 2, 0), 1, 15'h4321);
    add_row(cfg_a, mk_px(15'h2A55, 2, 0, 1, 0, 15'h7FFF, 3, 1), 1, 15'h2A55);
    add_row(cfg_a, mk_px(15'h5555, 6, 0, 1, 0, 15'h7FFF, 0, 0), 1, 15'h5555);
    add_row(cfg_a, mk_px(15'h0ABC, 5, 0, 1, 0, 15'h7FFF, 7, 0), 1, 15'h0ABC);
    add_row(cfg_a, mk_px(15'h1CE7, 4, 0, 1, 1, 15'h6318, 5, 0), 0, '0);
    // Weights above sixteen are clamped; then brighten and darken at full fade.
    add_row(cfg_b, mk_px(15'h4210, 0, 0, 1, 0, 15'h4210, 1, 0), 1, 15'h7FFF);
    add_row(cfg_b, mk_px(15'h3A5C, 1, 0, 1, 0, 15'h15A3, 4, 0), 0, '0);
    add_row(cfg_c, mk_px(15'h0000, 2, 0, 1, 0, 15'h7FFF, 0, 0), 1, 15'h7FFF);
    add_row(cfg_c, mk_px(15'h7FFF, 3, 0, 1, 0, 15'h0000, 0, 0), 1, 15'h7FFF);
    add_row(cfg_c, mk_px(15'h2D6B, 4, 0, 1, 1, 15'h7FFF, 0, 1), 0, '0);
    add_row(cfg_d, mk_px(15'h7FFF, 5, 0, 1, 0, 15'h0000, 0, 0), 1, 15'h0000);
    add_row(cfg_d, mk_px(15'h5AD6, 7, 0, 1, 0, 15'h1111, 0, 0), 1, 15'h5AD6);
    // Forced alpha from a semi-transparent object, and the cases that miss it.
    add_row(cfg_e, mk_px(15'h7FFF, 4, 0, 1, 1, 15'h0000, 0, 0), 1, 15'h3DEF);
    add_row(cfg_e, mk_px(15'h7FFF, 4, 0, 1, 1, 15'h0000, 1, 0), 1, 15'h7FFF);
    add_row(cfg_e, mk_px(15'h1357, 4, 0, 1, 1, 15'h7FFF, 0, 1), 1, 15'h1357);
    add_row(cfg_e, mk_px(15'h2468, 4, 0, 1, 0, 15'h7FFF, 0, 0), 1, 15'h2468);
    add_row(cfg_f, mk_px(15'h6B5A, 4, 0, 1, 1, 15'h3C0F, 0, 0), 0, '0);
    add_row(cfg_f, mk_px(15'h6B5A, 4, 0, 1, 0, 15'h3C0F, 0, 0), 0, '0);
    add_row(cfg_g, mk_px(15'h7FFF, 0, 0, 1, 0, 15'h7FFF, 1, 0), 1, 15'h0000);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 19;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cur_cfg) load_cfg(dir_rows[i].cfg);
      send_word(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int unsigned batch = 0; batch < 12; batch++) begin
      load_cfg(rand_cfg(batch));
      case (batch / 4)
        0:       idle_pct = 19;
        1:       idle_pct = 83;
        default: idle_pct = 0;
      endcase
      repeat (100) send_word(rand_pixel(), 1'b0, '0);
    end

    settle();
    if (fail_count == 0)
      $display("pixel_blend_effects: match");
    else
      $display("pixel_blend_effects: mismatch");
    $finish;
  end

endmodule
